// ===== design/raq_pkg.sv =====
// ---------------------------------------------------------------------------
// retransmit archive table package
// shared widths, item classes, back-end states and queue status
// ---------------------------------------------------------------------------
package raq_pkg;

  localparam int CAPACITY_DEF    = 16;
  localparam int HANDLE_BITS_DEF = 8;

  localparam int ADDR_W       = 32;
  localparam int SEQ_W        = 32;
  localparam int KIND_W       = 2;
  localparam int OUT_HANDLE_W = 8;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic              OP_ARCHIVE = 1'b0;
  localparam logic [KIND_W-1:0] KIND_DATA  = 2'd0;

  typedef enum logic [1:0] {
    CLS_SKIP,
    CLS_ARCHIVE,
    CLS_LOOKUP
  } cls_t;

  localparam int CLS_W = $bits(cls_t);

  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } bk_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== design/raq_front.sv =====
// ---------------------------------------------------------------------------
// retransmit archive front end
// takes requests, classifies them and packs them for the queue
// ---------------------------------------------------------------------------
module raq_front
  import raq_pkg::*;
#(
  parameter int HANDLE_BITS = HANDLE_BITS_DEF,
  parameter int DATA_W      = CLS_W + ADDR_W + SEQ_W + HANDLE_BITS
) (
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_operation,
  input  logic [KIND_W-1:0]       in_packet_kind,
  input  logic [ADDR_W-1:0]       in_peer_addr,
  input  logic [SEQ_W-1:0]        in_sequence_req,
  input  logic [OUT_HANDLE_W-1:0] in_buffer_handle,
  input  q_stat_t                 q_stat,
  output logic                    push,
  output logic [DATA_W-1:0]       push_data
);

  cls_t                   cls;
  logic [HANDLE_BITS-1:0] handle;

  always_comb begin
    if (in_operation != OP_ARCHIVE) begin
      cls = CLS_LOOKUP;
    end else if (in_packet_kind == KIND_DATA) begin
      cls = CLS_ARCHIVE;
    end else begin
      // non-data packets are never archived
      cls = CLS_SKIP;
    end
  end

  assign handle    = HANDLE_BITS'(in_buffer_handle);
  assign busy      = q_stat.full;
  assign push      = start && !q_stat.full;
  assign push_data = {cls, in_peer_addr, in_sequence_req, handle};

endmodule

// ===== design/raq_queue.sv =====
// ---------------------------------------------------------------------------
// retransmit archive request queue
// short fifo between the front end and the table engine
// ---------------------------------------------------------------------------
module raq_queue
  import raq_pkg::*;
#(
  parameter int DATA_W = CLS_W + ADDR_W + SEQ_W + HANDLE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] head_data,
  output q_stat_t           stat
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign head_data  = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

// ===== design/raq_back.sv =====
// ---------------------------------------------------------------------------
// retransmit archive table engine
// key compare against all slots, then insert with oldest-first eviction
// or lookup; a new request is popped only once the last one is done
// ---------------------------------------------------------------------------
module raq_back
  import raq_pkg::*;
#(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF,
  parameter int DATA_W      = CLS_W + ADDR_W + SEQ_W + HANDLE_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  q_stat_t                 q_stat,
  input  logic [DATA_W-1:0]       head_data,
  output logic                    pop,
  output logic                    out_strobe,
  output logic                    out_stored,
  output logic                    out_found,
  output logic [OUT_HANDLE_W-1:0] out_found_handle
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = CNT_W + 1;

  bk_state_t state_r, state_nxt;

  // slot storage
  logic [ADDR_W-1:0]      key_addr_r [CAPACITY];
  logic [SEQ_W-1:0]       key_seq_r  [CAPACITY];
  logic [HANDLE_BITS-1:0] handle_r   [CAPACITY];
  logic [CAPACITY-1:0]    valid_r, valid_nxt;
  logic [IDX_W-1:0]       oldest_r, oldest_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;

  // request held between compare and execute
  cls_t                   item_cls_r;
  logic [ADDR_W-1:0]      item_addr_r;
  logic [SEQ_W-1:0]       item_seq_r;
  logic [HANDLE_BITS-1:0] item_handle_r;
  logic [CAPACITY-1:0]    match_r;

  cls_t                   head_cls;
  logic [ADDR_W-1:0]      head_addr;
  logic [SEQ_W-1:0]       head_seq;
  logic [HANDLE_BITS-1:0] head_handle;
  logic [CAPACITY-1:0]    match;

  logic                   exec;
  logic                   hit;
  logic                   do_insert;
  logic                   tbl_full;
  logic [SUM_W-1:0]       slot_sum;
  logic [IDX_W-1:0]       ins_slot;
  logic [HANDLE_BITS-1:0] hit_handle;

  logic                   out_strobe_r;
  logic                   out_stored_r;
  logic                   out_found_r;
  logic [OUT_HANDLE_W-1:0] out_found_handle_r;

  assign head_cls    = cls_t'(head_data[DATA_W-1 -: CLS_W]);
  assign head_addr   = head_data[HANDLE_BITS+SEQ_W +: ADDR_W];
  assign head_seq    = head_data[HANDLE_BITS +: SEQ_W];
  assign head_handle = head_data[HANDLE_BITS-1:0];

  // parallel compare of the queue head against every slot
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match[i] = valid_r[i] && (key_addr_r[i] == head_addr) && (key_seq_r[i] == head_seq);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          state_nxt = BK_EXEC;
        end
      end
      BK_EXEC: state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    pop  = 1'b0;
    exec = 1'b0;
    case (state_r)
      BK_IDLE: pop  = !q_stat.empty;
      BK_EXEC: exec = 1'b1;
      default: begin
        pop  = 1'b0;
        exec = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item_cls_r    <= head_cls;
      item_addr_r   <= head_addr;
      item_seq_r    <= head_seq;
      item_handle_r <= head_handle;
      match_r       <= match;
    end
  end

  // keys are unique among valid slots, so at most one match bit is set
  always_comb begin
    hit_handle = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_handle = hit_handle | ({HANDLE_BITS{match_r[i]}} & handle_r[i]);
    end
  end

  assign hit       = |match_r;
  assign do_insert = exec && (item_cls_r == CLS_ARCHIVE) && !hit;
  assign tbl_full  = (count_r == CNT_W'(CAPACITY));

  // append slot is (oldest + count) mod capacity, sum stays below twice capacity
  assign slot_sum = SUM_W'(oldest_r) + SUM_W'(count_r);

  always_comb begin
    if (tbl_full) begin
      ins_slot = oldest_r;
    end else if (slot_sum >= SUM_W'(CAPACITY)) begin
      ins_slot = IDX_W'(slot_sum - SUM_W'(CAPACITY));
    end else begin
      ins_slot = IDX_W'(slot_sum);
    end
  end

  always_comb begin
    valid_nxt  = valid_r;
    oldest_nxt = oldest_r;
    count_nxt  = count_r;
    if (do_insert) begin
      valid_nxt[ins_slot] = 1'b1;
      if (tbl_full) begin
        // evict the oldest entry
        oldest_nxt = (oldest_r == IDX_W'(CAPACITY - 1)) ? '0 : oldest_r + 1'b1;
      end else begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      oldest_r <= '0;
      count_r  <= '0;
    end else begin
      valid_r  <= valid_nxt;
      oldest_r <= oldest_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_insert) begin
      key_addr_r[ins_slot] <= item_addr_r;
      key_seq_r[ins_slot]  <= item_seq_r;
      handle_r[ins_slot]   <= item_handle_r;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= exec;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_stored_r <= do_insert;
      out_found_r  <= (item_cls_r == CLS_LOOKUP) && hit;
      if ((item_cls_r == CLS_LOOKUP) && hit) begin
        out_found_handle_r <= OUT_HANDLE_W'(hit_handle);
      end else begin
        out_found_handle_r <= '0;
      end
    end
  end

  assign out_strobe       = out_strobe_r;
  assign out_stored       = out_stored_r;
  assign out_found        = out_found_r;
  assign out_found_handle = out_found_handle_r;

endmodule

// ===== design/retransmit_archive_table_unit.sv =====
// ---------------------------------------------------------------------------
// retransmit archive table unit
// archive of sent packets keyed by peer address and sequence, answering
// nak lookups with the stored buffer handle
// ---------------------------------------------------------------------------
// A request is taken on a clock edge with start high and busy low; busy is
// high only while the two-entry request queue is full. Each request gives
// exactly one result, shown for one cycle with out_strobe high; the receiver
// cannot hold results off, so they must be captured when the strobe is seen.
// The table engine handles one request at a time: the parallel key compare
// against all slots is registered as the request is popped from the queue,
// then the insert or lookup is done and the result registered, and only
// then is the next request popped. Archive requests of data packets with a
// new key are stored; once the table holds CAPACITY entries the oldest
// entry is overwritten.
module retransmit_archive_table_unit
  import raq_pkg::*;
#(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_operation,
  input  logic [KIND_W-1:0]       in_packet_kind,
  input  logic [ADDR_W-1:0]       in_peer_addr,
  input  logic [SEQ_W-1:0]        in_sequence_req,
  input  logic [OUT_HANDLE_W-1:0] in_buffer_handle,
  output logic                    out_strobe,
  output logic                    out_stored,
  output logic                    out_found,
  output logic [OUT_HANDLE_W-1:0] out_found_handle
);

  localparam int DATA_W = CLS_W + ADDR_W + SEQ_W + HANDLE_BITS;

  q_stat_t           q_stat;
  logic              push;
  logic              pop;
  logic [DATA_W-1:0] push_data;
  logic [DATA_W-1:0] head_data;

  raq_front #(
    .HANDLE_BITS (HANDLE_BITS),
    .DATA_W      (DATA_W)
  ) u_front (
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_packet_kind   (in_packet_kind),
    .in_peer_addr     (in_peer_addr),
    .in_sequence_req  (in_sequence_req),
    .in_buffer_handle (in_buffer_handle),
    .q_stat           (q_stat),
    .push             (push),
    .push_data        (push_data)
  );

  raq_queue #(
    .DATA_W (DATA_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head_data (head_data),
    .stat      (q_stat)
  );

  raq_back #(
    .CAPACITY    (CAPACITY),
    .HANDLE_BITS (HANDLE_BITS),
    .DATA_W      (DATA_W)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_stat           (q_stat),
    .head_data        (head_data),
    .pop              (pop),
    .out_strobe       (out_strobe),
    .out_stored       (out_stored),
    .out_found        (out_found),
    .out_found_handle (out_found_handle)
  );

endmodule
